>>> rtl/core/lcsle_pkg.sv
// Shared types and constants for the LCS length engine.
// No dependencies; every other file except lcsle_ram imports this package.
package lcsle_pkg;

  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned SCORE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [LEN_W-1:0] LEN_MAX_CODE = {LEN_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_FIRST  = 2'd0,
    KIND_SECOND = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;      // accepted character transaction
    logic init_pair;  // end of pair accepted, start the table
    logic row_rd;     // read the first-string character of the current row
    logic fetch;      // latch that character, reset the row's carries
    logic col;        // evaluate one table cell
    logic load_out;   // load the result register
    logic clear;      // empty both strings for the next pair
  } cmd_t;

  typedef struct packed {
    logic empty;      // either string holds no characters
    logic col_last;   // current cell is the last of its row
    logic row_last;   // current row is the last row
  } status_t;

endpackage

>>> rtl/core/lcsle_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used for the character stores and the score row.
module lcsle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/lcsle_ctrl.sv
// Sequencer for the LCS length engine: input handshake, table walk, result handshake.
// Depends on lcsle_pkg; drives the datapath through cmd_t and reads status_t.
module lcsle_ctrl
  import lcsle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  status_t    status_i,
  output cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROW   = 5'b00010,
    S_FETCH = 5'b00100,
    S_COL   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (kind_i) inside
            KIND_FIRST, KIND_SECOND: begin
              cmd_o.store = 1'b1;
            end
            KIND_END: begin
              cmd_o.init_pair = 1'b1;
              state_d = status_i.empty ? S_DONE : S_ROW;
            end
            default: ;
          endcase
        end
      end
      S_ROW: begin
        cmd_o.row_rd = 1'b1;
        state_d = S_FETCH;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d = S_COL;
      end
      S_COL: begin
        cmd_o.col = 1'b1;
        if (status_i.col_last) begin
          state_d = status_i.row_last ? S_DONE : S_ROW;
        end
      end
      S_DONE: begin
        // Hold the result here until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          cmd_o.clear    = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/lcsle_datapath.sv
// Datapath of the LCS length engine: character stores, score row, cell logic, result.
// Depends on lcsle_pkg and lcsle_ram; commanded by lcsle_ctrl.
module lcsle_datapath
  import lcsle_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       kind_i,
  input  logic [SYM_W-1:0] symbol_i,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  output logic [LEN_W-1:0] lcs_length_o,
  output logic             truncated_o
);

  logic [CNT_W-1:0]   first_cnt_q, second_cnt_q;
  logic               ovf_q;
  logic [ADDR_W-1:0]  row_q, col_q;
  logic               first_row_q;
  logic [SYM_W-1:0]   a_q;
  logic [SCORE_W-1:0] left_q, diag_q, lcs_q;
  logic [LEN_W-1:0]   lcs_out_q;
  logic               trunc_q;

  logic               first_full, second_full;
  logic               first_we, second_we;
  logic [SYM_W-1:0]   first_rd, second_rd;
  logic [SCORE_W-1:0] row_rd, up, cur;
  logic [ADDR_W-1:0]  col_raddr;

  assign first_full  = (first_cnt_q == CNT_W'(MAX_LEN));
  assign second_full = (second_cnt_q == CNT_W'(MAX_LEN));
  assign first_we    = cmd_i.store && (kind_i == KIND_FIRST) && !first_full;
  assign second_we   = cmd_i.store && (kind_i == KIND_SECOND) && !second_full;

  // While walking a row, prefetch the next column so one cell completes per cycle.
  assign col_raddr = cmd_i.col ? (col_q + ADDR_W'(1)) : '0;

  lcsle_ram #(.Width(SYM_W), .Depth(MAX_LEN)) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (first_we),
    .waddr_i (first_cnt_q[ADDR_W-1:0]),
    .wdata_i (symbol_i),
    .raddr_i (row_q),
    .rdata_o (first_rd)
  );

  lcsle_ram #(.Width(SYM_W), .Depth(MAX_LEN)) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (second_we),
    .waddr_i (second_cnt_q[ADDR_W-1:0]),
    .wdata_i (symbol_i),
    .raddr_i (col_raddr),
    .rdata_o (second_rd)
  );

  // One score row updated in place; the old value of the left neighbor lives in diag_q.
  lcsle_ram #(.Width(SCORE_W), .Depth(MAX_LEN)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.col),
    .waddr_i (col_q),
    .wdata_i (cur),
    .raddr_i (col_raddr),
    .rdata_o (row_rd)
  );

  // The row above the first row is all zero, so the stale row is never cleared.
  assign up  = first_row_q ? '0 : row_rd;
  assign cur = (a_q == second_rd) ? (diag_q + SCORE_W'(1))
                                  : ((left_q > up) ? left_q : up);

  assign status_o.empty    = (first_cnt_q == '0) || (second_cnt_q == '0);
  assign status_o.col_last = (col_q == ADDR_W'(second_cnt_q - CNT_W'(1)));
  assign status_o.row_last = (row_q == ADDR_W'(first_cnt_q - CNT_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      ovf_q        <= 1'b0;
      row_q        <= '0;
      col_q        <= '0;
      first_row_q  <= 1'b1;
    end else begin
      if (cmd_i.store) begin
        if (kind_i == KIND_FIRST) begin
          if (first_full) begin
            ovf_q <= 1'b1;
          end else begin
            first_cnt_q <= first_cnt_q + CNT_W'(1);
          end
        end else if (kind_i == KIND_SECOND) begin
          if (second_full) begin
            ovf_q <= 1'b1;
          end else begin
            second_cnt_q <= second_cnt_q + CNT_W'(1);
          end
        end
      end
      if (cmd_i.clear) begin
        first_cnt_q  <= '0;
        second_cnt_q <= '0;
        ovf_q        <= 1'b0;
      end
      if (cmd_i.init_pair) begin
        row_q       <= '0;
        first_row_q <= 1'b1;
      end
      if (cmd_i.row_rd) begin
        col_q <= '0;
      end
      if (cmd_i.col) begin
        if (status_o.col_last) begin
          if (!status_o.row_last) begin
            row_q       <= row_q + ADDR_W'(1);
            first_row_q <= 1'b0;
          end
        end else begin
          col_q <= col_q + ADDR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_pair) begin
      lcs_q <= '0;
    end
    if (cmd_i.fetch) begin
      a_q    <= first_rd;
      left_q <= '0;
      diag_q <= '0;
    end
    if (cmd_i.col) begin
      left_q <= cur;
      diag_q <= up;
      if (status_o.col_last && status_o.row_last) begin
        lcs_q <= cur;
      end
    end
    if (cmd_i.load_out) begin
      lcs_out_q <= (lcs_q > SCORE_W'(LEN_MAX_CODE)) ? LEN_MAX_CODE : lcs_q[LEN_W-1:0];
      trunc_q   <= ovf_q;
    end
  end

  assign lcs_length_o = lcs_out_q;
  assign truncated_o  = trunc_q;

endmodule

>>> rtl/core/lcs_length_engine_core.sv
// LCS length engine. Character transactions are taken one per cycle while the engine is idle.
// An end-of-pair transaction starts the table walk, or goes straight to the result
// when either string is empty; each row takes a row read, a fetch and then a step for
// each cell of the second string. The input is ready again once the result is loaded.
// Reset clears the counts, the overflow flag and the result valid flag; the character
// stores are not cleared, only entries below the counts are ever used.
module lcs_length_engine_core
  import lcsle_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       kind_i,
  input  logic [SYM_W-1:0] symbol_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [LEN_W-1:0] lcs_length_o,
  output logic             truncated_o
);

  cmd_t    cmd;
  status_t status;

  lcsle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lcsle_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (kind_i),
    .symbol_i     (symbol_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .lcs_length_o (lcs_length_o),
    .truncated_o  (truncated_o)
  );

endmodule

>>> rtl/core/lcsle_checker.sv
// Port-level checks for the LCS length engine, bound to the top level.
// Depends on lcsle_pkg; sees only the ports of lcs_length_engine_core.
module lcsle_checker
  import lcsle_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [1:0]       kind_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [LEN_W-1:0] lcs_length_o,
  input logic             truncated_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result transaction dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(lcs_length_o) && $stable(truncated_o))
    else $error("result payload changed while stalled");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($unsigned(lcs_length_o) <= MAX_LEN))
    else $error("result length exceeds the string capacity");

  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (kind_i == KIND_END) |=> !in_ready_o)
    else $error("input taken right after an end of pair");

  a_char_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_acc && (kind_i != KIND_END) |=> !out_valid_o)
    else $error("result appeared after a character transaction");

endmodule

bind lcs_length_engine_core lcsle_checker u_lcsle_checker (.*);

>>> tb/sv/lcs_length_checker.sv
// Scoreboard for the LCS length engine: watches both channels, predicts each result
// and compares it field by field. Depends on lcsle_pkg only.
`timescale 1ns / 100ps
module lcs_length_checker
  import lcsle_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [1:0]       kind_i,
  input  logic [SYM_W-1:0] symbol_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [LEN_W-1:0] lcs_length_i,
  input  logic             truncated_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             truncated;
  } lcs_result_t;

  logic [SYM_W-1:0] first_str [MAX_LEN];
  logic [SYM_W-1:0] second_str [MAX_LEN];
  int unsigned      first_len = 0;
  int unsigned      second_len = 0;
  logic             cut_seen = 1'b0;
  lcs_result_t      awaited_q [$];
  int               fails = 0;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  // Two-row dynamic program over the strings stored so far.
  function automatic logic [LEN_W-1:0] lcs_of_stored_pair();
    int unsigned prev_row [MAX_LEN+1];
    int unsigned cur_row [MAX_LEN+1];
    int unsigned best;
    for (int j = 0; j <= MAX_LEN; j++) begin
      prev_row[j] = 0;
      cur_row[j] = 0;
    end
    for (int i = 1; i <= first_len; i++) begin
      for (int j = 1; j <= second_len; j++) begin
        if (first_str[i-1] == second_str[j-1]) begin
          cur_row[j] = prev_row[j-1] + 1;
        end else begin
          cur_row[j] = (cur_row[j-1] > prev_row[j]) ? cur_row[j-1] : prev_row[j];
        end
      end
      prev_row = cur_row;
    end
    best = cur_row[second_len];
    if (best > LEN_MAX_CODE) best = LEN_MAX_CODE;
    return best[LEN_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lcs_result_t oldest;
    lcs_result_t fresh;
    if (!rst_ni) begin
      first_len = 0;
      second_len = 0;
      cut_seen = 1'b0;
      awaited_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: result with nothing expected, lcs_length %0d truncated %0b",
                   $time, lcs_length_i, truncated_i);
          fails++;
        end else begin
          oldest = awaited_q.pop_front();
          if (lcs_length_i !== oldest.length) begin
            $display("%0t: lcs_length mismatch, expected %0d actual %0d",
                     $time, oldest.length, lcs_length_i);
            fails++;
          end
          if (truncated_i !== oldest.truncated) begin
            $display("%0t: truncated mismatch, expected %0b actual %0b",
                     $time, oldest.truncated, truncated_i);
            fails++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (kind_i == KIND_FIRST) begin
          if (first_len < MAX_LEN) begin
            first_str[first_len] = symbol_i;
            first_len++;
          end else begin
            cut_seen = 1'b1;
          end
        end else if (kind_i == KIND_SECOND) begin
          if (second_len < MAX_LEN) begin
            second_str[second_len] = symbol_i;
            second_len++;
          end else begin
            cut_seen = 1'b1;
          end
        end else if (kind_i == KIND_END) begin
          fresh.length = lcs_of_stored_pair();
          fresh.truncated = cut_seen;
          awaited_q.push_back(fresh);
          first_len = 0;
          second_len = 0;
          cut_seen = 1'b0;
        end
        // The unused kind code leaves everything untouched.
      end
      pending_o <= awaited_q.size();
    end
    fail_count_o <= fails;
  end

  final begin
    if (awaited_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, awaited_q.size());
    end
  end

endmodule

>>> tb/sv/lcs_length_engine_core_tb.sv
// Top of the LCS length engine testbench: clock, reset, stimulus and verdict.
// Depends on lcsle_pkg, lcs_length_engine_core and lcs_length_checker.
`timescale 1ns / 100ps
module lcs_length_engine_core_tb;
  import lcsle_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned HOLD_AT      = 12;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       kind = KIND_END;
  logic [SYM_W-1:0] symbol = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [LEN_W-1:0] lcs_length;
  logic             truncated;
  int               fail_count;
  int               pending;

  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;
  int unsigned pair_items = 0;
  int unsigned results_taken = 0;
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;

  lcs_length_engine_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (kind),
    .symbol_i    (symbol),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .lcs_length_o(lcs_length),
    .truncated_o (truncated)
  );

  lcs_length_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .kind_i      (kind),
    .symbol_i    (symbol),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .lcs_length_i(lcs_length),
    .truncated_i (truncated),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random back-pressure, plus one long hold-off once a few results are in.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) results_taken++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_used && results_taken == HOLD_AT) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_pct);
      end
    end
  end

  // Valid stays high across back-to-back transactions; it only drops in a gap.
  task automatic send_item(input logic [1:0] kind_val, input logic [SYM_W-1:0] sym);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= kind_val;
    symbol <= sym;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_random_pair(input int unsigned pair_idx);
    logic [SYM_W-1:0] first_buf [$];
    logic [SYM_W-1:0] second_buf [$];
    logic [SYM_W-1:0] alphabet [4];
    logic [SYM_W-1:0] sym;
    int unsigned first_n, second_n, roll, fi, si;
    bit wide_symbols, interleave, take_first;
    roll = $urandom_range(0, 99);
    if (pair_idx == 0) begin
      first_n = MAX_LEN + $urandom_range(1, 4);
      second_n = $urandom_range(1, MAX_LEN);
    end else if (pair_idx == 1) begin
      first_n = MAX_LEN;
      second_n = MAX_LEN;
    end else if (roll < 75) begin
      first_n = $urandom_range(0, 8);
      second_n = $urandom_range(0, 8);
    end else if (roll < 93) begin
      first_n = $urandom_range(9, 24);
      second_n = $urandom_range(9, 24);
    end else begin
      first_n = $urandom_range(MAX_LEN - 24, MAX_LEN + 6);
      second_n = $urandom_range(MAX_LEN - 24, MAX_LEN + 6);
    end
    // A small alphabet makes long common subsequences likely.
    wide_symbols = (pair_idx == 0) || ($urandom_range(0, 99) < 20);
    interleave = $urandom_range(0, 1);
    for (int k = 0; k < 4; k++) alphabet[k] = SYM_W'($urandom_range(0, 255));
    for (int k = 0; k < first_n; k++) begin
      sym = wide_symbols ? 8'($urandom_range(0, 255)) : alphabet[$urandom_range(0, 3)];
      first_buf.push_back(sym);
    end
    for (int k = 0; k < second_n; k++) begin
      if (pair_idx == 1) begin
        sym = first_buf[k];
      end else begin
        sym = wide_symbols ? 8'($urandom_range(0, 255)) : alphabet[$urandom_range(0, 3)];
      end
      second_buf.push_back(sym);
    end
    fi = 0;
    si = 0;
    while (fi < first_n || si < second_n) begin
      if ($urandom_range(0, 99) < 3) send_item(KIND_UNUSED, SYM_W'($urandom_range(0, 255)));
      take_first = (si >= second_n) || (fi < first_n && (!interleave || $urandom_range(0, 1)));
      if (take_first) begin
        send_item(KIND_FIRST, first_buf[fi]);
        fi++;
      end else begin
        send_item(KIND_SECOND, second_buf[si]);
        si++;
      end
    end
    send_item(KIND_END, SYM_W'($urandom_range(0, 255)));
    pair_items += first_n + second_n + 1;
  endtask

  initial begin
    int unsigned pair_no;
    int unsigned phase;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_pct = 28;
    recv_pct = 58;

    // Both strings empty, then each side empty alone.
    send_item(KIND_END, 8'hFF);
    send_item(KIND_FIRST, 8'h00);
    send_item(KIND_END, 8'h00);
    send_item(KIND_SECOND, 8'hFF);
    send_item(KIND_END, 8'h00);
    // Unused kind between pairs and inside a pair must change nothing.
    send_item(KIND_UNUSED, 8'hA5);
    send_item(KIND_FIRST, 8'h00);
    send_item(KIND_FIRST, 8'hFF);
    send_item(KIND_SECOND, 8'hFF);
    send_item(KIND_SECOND, 8'h00);
    send_item(KIND_UNUSED, 8'h5A);
    send_item(KIND_END, 8'h00);
    send_item(KIND_SECOND, 8'h55);
    send_item(KIND_FIRST, 8'h55);
    send_item(KIND_SECOND, 8'hAA);
    send_item(KIND_FIRST, 8'hAA);
    send_item(KIND_END, 8'hFF);

    // The first random pair overfills a string; the second is two identical full strings.
    pair_no = 0;
    phase = 0;
    while (pair_items < RANDOM_ITEMS) begin
      if (phase == 0 && pair_items >= RANDOM_ITEMS / 3) begin
        wait_drained();
        phase = 1;
        send_pct = 58;
        recv_pct = 28;
      end else if (phase == 1 && pair_items >= 2 * RANDOM_ITEMS / 3) begin
        wait_drained();
        phase = 2;
        send_pct = 0;
        recv_pct = 0;
      end
      send_random_pair(pair_no);
      pair_no++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("lcs_length_engine_core_tb OK");
    end else begin
      $display("lcs_length_engine_core_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("lcs_length_engine_core_tb NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lcsle_pkg.sv
rtl/core/lcsle_ram.sv
rtl/core/lcsle_ctrl.sv
rtl/core/lcsle_datapath.sv
rtl/core/lcs_length_engine_core.sv
rtl/core/lcsle_checker.sv
tb/sv/lcs_length_checker.sv
tb/sv/lcs_length_engine_core_tb.sv
